// File: design/smx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants for the softmax/argmax classifier
// Holds widths, the fraction table and the controller-datapath command types.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int CLASSES     = 6;
  localparam int SCORE_WIDTH = 16;
  localparam int IDX_W       = 3;
  localparam int EXP_W       = 17;
  localparam int SUM_W       = 20;
  localparam int PROB_W      = 16;
  localparam int DIV_STEPS   = 34;
  localparam int DIVC_W      = 6;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] FRAC_STEP = 32'd4283353945;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic load;
    logic clr_sum;
    logic exp_issue;
    logic exp_acc;
    logic div_start;
    logic emit;
    idx_t sel;
    logic last;
  } smx_cmd_t;

  typedef struct packed {
    logic vec_done;
    logic div_done;
  } smx_sts_t;

  // 2^(-f/256) in Q1.16 for f = 0..255, packed entry by entry
  function automatic logic [256*EXP_W-1:0] frac_rom_build();
    logic [256*EXP_W-1:0] tab;
    logic [63:0]          p;
    tab = '0;
    p   = 64'd1 << 32;
    for (int k = 0; k < 256; k++) begin
      tab[k*EXP_W +: EXP_W] = EXP_W'((p + 64'd32768) >> 16);
      p = (p * {32'd0, FRAC_STEP} + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam logic [256*EXP_W-1:0] FRAC_ROM = frac_rom_build();

endpackage
`default_nettype wire

// File: design/softmax_argmax_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// softmax_argmax_classifier: softmax with argmax over CLASSES scores
// A non-final score is stored without raising busy; the final score holds busy
// through the exponent pass, then per class a start state, a 34-step serial
// divide and an emit state; the last result shows on the first idle cycle.
// No new score is taken while busy; the receiver cannot stall.
// Reset clears fill count, running max and the sequencer.
// ----------------------------------------------------------------------------
module softmax_argmax_classifier (
  input  wire  logic                       clk,
  input  wire  logic                       rst,
  input  wire  logic                       start,
  input  wire  logic signed [15:0]         score,
  output       logic                       busy,
  output       logic                       strobe,
  output       logic [15:0]                probability,
  output       logic [2:0]                 class_index,
  output       logic [2:0]                 winner,
  output       logic                       last
);
  import smx_pkg::*;

  smx_cmd_t cmd;
  smx_sts_t sts;

  smx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  smx_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .score       (score),
    .cmd         (cmd),
    .sts         (sts),
    .strobe      (strobe),
    .probability (probability),
    .class_index (class_index),
    .winner      (winner),
    .last        (last)
  );

  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> strobe) else $error("emit without strobe");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy) else $error("load while busy");
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy) else $error("busy after final result");

endmodule
`default_nettype wire

// File: design/smx_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ctrl: sequencer for the softmax/argmax classifier
// Walks the exponent pass, then per class one division followed by an emit.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              start,
  input  wire  smx_pkg::smx_sts_t sts,
  output       smx_pkg::smx_cmd_t cmd,
  output       logic              busy
);
  import smx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXP  = 5'b00010,
    S_DIVS = 5'b00100,
    S_DIVW = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;
  idx_t   cnt, cnt_next;
  logic   acc, acc_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    acc_next   = 1'b0;
    cmd        = '0;
    cmd.sel    = cnt;
    cmd.last   = (cnt == idx_t'(CLASSES - 1));
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start && sts.vec_done) begin
          state_next  = S_EXP;
          cnt_next    = '0;
          cmd.clr_sum = 1'b1;
        end
      end
      S_EXP: begin
        cmd.exp_issue = 1'b1;
        cmd.exp_acc   = acc;
        acc_next      = 1'b1;
        if (cnt == idx_t'(CLASSES - 1)) begin
          state_next = S_DIVS;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIVS: begin
        cmd.exp_acc   = acc;
        cmd.div_start = ~acc;
        if (!acc) state_next = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (cnt == idx_t'(CLASSES - 1)) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          state_next = S_DIVS;
          cnt_next   = cnt + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      acc   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      acc   <= acc_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// File: design/smx_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smx_datapath: score store, running max, exponent unit and serial divider
// Exponent is pipelined two stages; division is restoring, one bit a cycle.
// ----------------------------------------------------------------------------
module smx_datapath (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic signed [15:0]            score,
  input  wire  smx_pkg::smx_cmd_t             cmd,
  output       smx_pkg::smx_sts_t             sts,
  output       logic                          strobe,
  output       logic [smx_pkg::PROB_W-1:0]    probability,
  output       logic [smx_pkg::IDX_W-1:0]     class_index,
  output       logic [smx_pkg::IDX_W-1:0]     winner,
  output       logic                          last
);
  import smx_pkg::*;

  logic signed [SCORE_WIDTH-1:0] score_store [CLASSES];
  logic [EXP_W-1:0]              exp_store   [CLASSES];
  logic [IDX_W-1:0]              fill_count;
  logic signed [SCORE_WIDTH-1:0] running_max;
  idx_t                          max_position;
  logic [SUM_W-1:0]              exp_sum;

  logic signed [SCORE_WIDTH-1:0] s_in;
  logic                          first;
  logic                          vec_done;
  assign s_in     = SCORE_WIDTH'(score);
  assign first    = (fill_count == '0);
  assign vec_done = (fill_count == IDX_W'(CLASSES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      running_max  <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
      max_position <= '0;
    end else if (cmd.load) begin
      if (first || s_in > running_max) begin
        running_max  <= s_in;
        max_position <= fill_count;
      end
      fill_count <= vec_done ? '0 : fill_count + 1'b1;
    end else if (cmd.emit && cmd.last) begin
      running_max  <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
      max_position <= '0;
    end
  end

  logic signed [SCORE_WIDTH-1:0] vec_max;
  assign vec_max = running_max;

  always_ff @(posedge clk) begin
    if (cmd.load) score_store[fill_count] <= s_in;
  end

  // stage 1: distance times log2(e)
  logic [SCORE_WIDTH-1:0]  distance;
  logic [SCORE_WIDTH+17:0] v_prod;
  idx_t  e_idx;
  assign distance = $unsigned(SCORE_WIDTH'(vec_max - score_store[cmd.sel]));
  always_ff @(posedge clk) begin
    if (cmd.exp_issue) begin
      v_prod <= (SCORE_WIDTH+18)'(distance) * (SCORE_WIDTH+18)'(LOG2E_Q16)
                + (SCORE_WIDTH+18)'(32768);
      e_idx  <= cmd.sel;
    end
  end

  // stage 2: base-2 split and table lookup
  logic [SCORE_WIDTH+1:0] v;
  logic [SCORE_WIDTH-7:0] n;
  logic [EXP_W-1:0]       frac_val;
  logic [EXP_W-1:0]       e_val;
  assign v        = v_prod[SCORE_WIDTH+17:16];
  assign n        = v[SCORE_WIDTH+1:8];
  assign frac_val = FRAC_ROM[int'(v[7:0])*EXP_W +: EXP_W];
  assign e_val    = (n >= (SCORE_WIDTH-6)'(17)) ? '0 : (frac_val >> n[4:0]);

  always_ff @(posedge clk) begin
    if (cmd.exp_acc) exp_store[e_idx] <= e_val;
  end

  always_ff @(posedge clk) begin
    if (rst) exp_sum <= '0;
    else if (cmd.clr_sum) exp_sum <= '0;
    else if (cmd.exp_acc) exp_sum <= exp_sum + SUM_W'(e_val);
  end

  // serial restoring divider: (e*65536 + sum/2) / sum
  logic [EXP_W+16:0]  dvd;
  logic [SUM_W:0]     rem;
  logic [DIVC_W-1:0]  dcnt;
  logic               dbusy;
  logic [SUM_W+1:0]   trial;
  assign trial = {rem, dvd[EXP_W+16]} - {2'b0, exp_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (cmd.div_start) begin
      dvd   <= {exp_store[cmd.sel], 16'd0} + (EXP_W+17)'(exp_sum >> 1);
      rem   <= '0;
      dbusy <= 1'b1;
      dcnt  <= '0;
    end else if (dbusy) begin
      if (!trial[SUM_W+1]) begin
        rem <= trial[SUM_W:0];
        dvd <= {dvd[EXP_W+15:0], 1'b1};
      end else begin
        rem <= {rem[SUM_W-1:0], dvd[EXP_W+16]};
        dvd <= {dvd[EXP_W+15:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
      if (dcnt == DIVC_W'(DIV_STEPS - 1)) dbusy <= 1'b0;
    end
  end

  assign sts = '{vec_done: vec_done,
                 div_done: dbusy && (dcnt == DIVC_W'(DIV_STEPS - 1))};

  logic [PROB_W-1:0] q_sat;
  assign q_sat = (dvd[EXP_W+16:16] != '0) ? '1 : dvd[15:0];

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= cmd.emit;
    if (cmd.emit) begin
      probability <= q_sat;
      class_index <= cmd.sel;
      winner      <= max_position;
      last        <= cmd.last;
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_softmax_argmax_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_softmax_argmax_classifier: self-checking bench for the softmax classifier
// Feeds score vectors (directed table, then random bursts) and checks every
// probability, class index, winner and last flag against a local predictor.
// ----------------------------------------------------------------------------
module tb_softmax_argmax_classifier;
  import smx_pkg::*;

  typedef struct {
    logic [15:0] prob;
    logic [2:0]  cls;
    logic [2:0]  win;
    logic        lst;
    bit          tchk;
    logic [2:0]  twin;
  } prob_txn_t;

  typedef struct {
    logic signed [15:0] score;
    bit                 chk;
    logic [2:0]         win;
  } score_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic signed [15:0] score;
  logic               busy;
  logic               strobe;
  logic [15:0]        probability;
  logic [2:0]         class_index;
  logic [2:0]         winner;
  logic               last;

  prob_txn_t   prob_q[$];
  logic [16:0] frac_lut[256];
  logic signed [15:0] vec_scores[CLASSES];
  int          vec_fill;
  logic signed [15:0] vec_max;
  int          vec_winner;
  int          mismatches;
  int          dir_row;
  score_row_t  rows[$];

  softmax_argmax_classifier DUT (
    .clk(clk), .rst(rst), .start(start), .score(score), .busy(busy),
    .strobe(strobe), .probability(probability), .class_index(class_index),
    .winner(winner), .last(last)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic logic [16:0] exp_term(longint distance);
    longint v;
    longint n;
    v = (distance * 94548 + 32768) >>> 16;
    n = v >>> 8;
    if (n >= 17) return 17'd0;
    return frac_lut[v & 255] >> n;
  endfunction

  task automatic predict_score(input logic signed [15:0] s);
    logic [16:0] e[CLASSES];
    logic [19:0] total;
    longint      q;
    prob_txn_t   t;
    if (vec_fill == 0 || s > vec_max) begin
      vec_max = s;
      vec_winner = vec_fill;
    end
    vec_scores[vec_fill] = s;
    vec_fill++;
    if (vec_fill < CLASSES) return;
    total = '0;
    for (int i = 0; i < CLASSES; i++) begin
      e[i] = exp_term(longint'(vec_max) - longint'(vec_scores[i]));
      total = total + 20'(e[i]);
    end
    for (int i = 0; i < CLASSES; i++) begin
      q = 65535;
      if (total != 0) q = (longint'(e[i]) * 65536 + total / 2) / total;
      if (q > 65535) q = 65535;
      t.prob = q[15:0];
      t.cls = 3'(i);
      t.win = 3'(vec_winner);
      t.lst = (i == CLASSES - 1);
      t.tchk = 1'b0;
      t.twin = '0;
      if (dir_row >= 0) begin
        t.tchk = rows[dir_row].chk && (i == CLASSES - 1);
        t.twin = rows[dir_row].win;
      end
      prob_q = {prob_q, t};
    end
    vec_fill = 0;
  endtask

  task automatic send_score(input logic signed [15:0] s);
    start <= 1'b1;
    score <= s;
    do @(posedge clk); while (busy);
    predict_score(s);
  endtask

  always @(posedge clk) begin
    prob_txn_t exp_t;
    if (!rst && strobe) begin
      if (prob_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction cls=%0d", class_index);
      end else begin
        exp_t = prob_q.pop_front();
        if (exp_t.tchk && winner !== exp_t.twin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table winner exp=%0d got=%0d", exp_t.twin, winner);
        end
        if (probability !== exp_t.prob || class_index !== exp_t.cls ||
            winner !== exp_t.win || last !== exp_t.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp p=%0d c=%0d w=%0d l=%0d got p=%0d c=%0d w=%0d l=%0d",
                     exp_t.prob, exp_t.cls, exp_t.win, exp_t.lst,
                     probability, class_index, winner, last);
        end
      end
    end
  end

  task automatic add_vec(input logic signed [15:0] a, b, c, d, e, f,
                         input bit chk, input logic [2:0] w);
    logic signed [15:0] v[6];
    score_row_t r;
    v = '{a, b, c, d, e, f};
    for (int i = 0; i < 6; i++) begin
      r.score = v[i];
      r.chk = chk && (i == 5);
      r.win = w;
      rows = {rows, r};
    end
  endtask

  initial begin
    logic [63:0] p;
    int gap;
    int burst;
    int kind;
    logic signed [15:0] base;
    for (int f = 0; f < 256; f++) begin
      p = 64'd1 << 32;
      for (int k = 0; k < f; k++) p = (p * 64'd4283353945 + (64'd1 << 31)) >> 32;
      frac_lut[f] = 17'((p + 64'd32768) >> 16);
    end
    rst = 1'b1; start = 1'b0; score = '0;
    mismatches = 0; vec_fill = 0; vec_max = '0; vec_winner = 0; dir_row = -1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_vec(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 3'd0);
    add_vec(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
            1'b1, 3'd2);
    add_vec(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
            1'b1, 3'd0);
    add_vec(16'sh8000, 16'sh8001, 16'sd5, 16'sd5, -16'sd1, 16'sd5, 1'b1, 3'd2);
    add_vec(16'sh5555, -16'sh5556, 16'sd1, -16'sd2, 16'sd256, 16'sd256,
            1'b1, 3'd0);
    for (int i = 0; i < rows.size(); i++) begin
      dir_row = i;
      send_score(rows[i].score);
    end
    start <= 1'b0;
    while (prob_q.size() != 0) @(posedge clk);
    dir_row = -1;

    for (int n = 0; n < 180;) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < 180; b++, n++) begin
        kind = $urandom_range(0, 3);
        if (vec_fill == 0) base = 16'($urandom);
        case (kind)
          0: send_score(16'($urandom));
          1: send_score(16'(base + $signed(16'($urandom_range(0, 1024))) - 16'sd512));
          2: send_score(16'(base + $signed(16'($urandom_range(0, 8))) - 16'sd4));
          default: send_score(($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000);
        endcase
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    while (vec_fill != 0) send_score(16'($urandom));
    start <= 1'b0;
    while (prob_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && prob_q.size() == 0) begin
      $display("softmax_argmax_classifier: match");
    end else begin
      $display("softmax_argmax_classifier: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("softmax_argmax_classifier: mismatch");
    $finish;
  end

endmodule

// File: softmax_argmax_classifier.f
design/smx_pkg.sv
design/smx_ctrl.sv
design/smx_datapath.sv
design/softmax_argmax_classifier.sv
dv/tb_softmax_argmax_classifier.sv
